// ===== src/cau_pkg.sv =====
// Shared types, constants and helper functions of the complex arithmetic unit.
`default_nettype none
package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;

    // Derived widths
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int SUM_W      = PROD_W + 1;
    localparam int NUM_W      = PROD_W + FRAC_BITS;
    localparam int QUO_W      = DATA_WIDTH + 1;
    localparam int DIV_STAGES = QUO_W;

    localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [PROD_W-1:0]     MAG_LIM = PROD_W'(1) << (DATA_WIDTH - 1);
    localparam logic [PROD_W-1:0]     MAG_MAX = MAG_LIM - PROD_W'(1);
    localparam logic signed [DATA_WIDTH:0] SUM_HI = {2'b00, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH:0] SUM_LO = {2'b11, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] val;
        logic                  sat;
    } sat_t;

    // Front stage 1: raw products and add/subtract results
    typedef struct packed {
        op_t                       op;
        logic signed [PROD_W-1:0]  p_rr;
        logic signed [PROD_W-1:0]  p_ii;
        logic signed [PROD_W-1:0]  p_ir;
        logic signed [PROD_W-1:0]  p_ri;
        logic signed [PROD_W-1:0]  sq_r;
        logic signed [PROD_W-1:0]  sq_i;
        logic [DATA_WIDTH-1:0]     add_re;
        logic [DATA_WIDTH-1:0]     add_im;
        logic                      add_sat;
    } cau_s1_t;

    // Front stage 2: product sums, divisor and carried add/subtract results
    typedef struct packed {
        op_t                       op;
        logic signed [SUM_W-1:0]   s_re;
        logic signed [SUM_W-1:0]   s_im;
        logic [PROD_W-1:0]         den;
        logic [DATA_WIDTH-1:0]     add_re;
        logic [DATA_WIDTH-1:0]     add_im;
        logic                      add_sat;
    } cau_s2_t;

    // One divider lane
    typedef struct packed {
        logic              neg;
        logic              ovf;
        logic [PROD_W-1:0] rem;
        logic [QUO_W-1:0]  num;
        logic [QUO_W-1:0]  quo;
    } cau_lane_t;

    // Divider pipeline word
    typedef struct packed {
        op_t                   op;
        logic                  dz;
        logic [DATA_WIDTH-1:0] fast_re;
        logic [DATA_WIDTH-1:0] fast_im;
        logic                  fast_sat;
        logic [PROD_W-1:0]     den;
        cau_lane_t             re;
        cau_lane_t             im;
    } cau_div_t;

    // Saturate a sign and magnitude to one word
    function automatic sat_t sat_mag(input logic neg, input logic [PROD_W-1:0] mag);
        sat_t              r;
        logic [PROD_W-1:0] neg_mag;
        neg_mag = -mag;
        r.sat = 1'b0;
        r.val = mag[DATA_WIDTH-1:0];
        if (!neg) begin
            if (mag > MAG_MAX) begin
                r.val = MAX_VAL;
                r.sat = 1'b1;
            end
        end else begin
            if (mag > MAG_LIM) begin
                r.val = MIN_VAL;
                r.sat = 1'b1;
            end else begin
                r.val = neg_mag[DATA_WIDTH-1:0];
            end
        end
        return r;
    endfunction

    // Saturate a one-bit-wider sum to one word
    function automatic sat_t sat_sum(input logic signed [DATA_WIDTH:0] v);
        sat_t r;
        r.sat = 1'b0;
        r.val = v[DATA_WIDTH-1:0];
        if (v > SUM_HI) begin
            r.val = MAX_VAL;
            r.sat = 1'b1;
        end else if (v < SUM_LO) begin
            r.val = MIN_VAL;
            r.sat = 1'b1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/cau_front.sv =====
// Front end: operand products, add/subtract, and product sums over two register stages.
`default_nettype none
module cau_front (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    en,
    input  wire logic                                    vld_in,
    input  wire logic [1:0]                              req_type,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0]   a_re,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0]   a_im,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0]   b_re,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0]   b_im,
    output logic                                         vld_out,
    output cau_pkg::cau_s2_t                             d_out
);

    cau_pkg::cau_s1_t s1_next, s1_reg;
    cau_pkg::cau_s2_t s2_next, s2_reg;
    logic             s1_vld_reg, s2_vld_reg;

    logic signed [cau_pkg::DATA_WIDTH:0] sum_re, sum_im;
    cau_pkg::sat_t                       sr, si;

    logic signed [cau_pkg::SUM_W-1:0] e_rr, e_ii, e_ir, e_ri, e_qr, e_qi, den_full;

    // Stage 1: products and add/subtract
    always_comb
    begin
        s1_next.op = cau_pkg::op_t'(req_type);
        s1_next.p_rr = cau_pkg::PROD_W'(a_re) * cau_pkg::PROD_W'(b_re);
        s1_next.p_ii = cau_pkg::PROD_W'(a_im) * cau_pkg::PROD_W'(b_im);
        s1_next.p_ir = cau_pkg::PROD_W'(a_im) * cau_pkg::PROD_W'(b_re);
        s1_next.p_ri = cau_pkg::PROD_W'(a_re) * cau_pkg::PROD_W'(b_im);
        s1_next.sq_r = cau_pkg::PROD_W'(b_re) * cau_pkg::PROD_W'(b_re);
        s1_next.sq_i = cau_pkg::PROD_W'(b_im) * cau_pkg::PROD_W'(b_im);
        if (cau_pkg::op_t'(req_type) == cau_pkg::OP_SUB)
        begin
            sum_re = {a_re[cau_pkg::DATA_WIDTH-1], a_re} - {b_re[cau_pkg::DATA_WIDTH-1], b_re};
            sum_im = {a_im[cau_pkg::DATA_WIDTH-1], a_im} - {b_im[cau_pkg::DATA_WIDTH-1], b_im};
        end
        else
        begin
            sum_re = {a_re[cau_pkg::DATA_WIDTH-1], a_re} + {b_re[cau_pkg::DATA_WIDTH-1], b_re};
            sum_im = {a_im[cau_pkg::DATA_WIDTH-1], a_im} + {b_im[cau_pkg::DATA_WIDTH-1], b_im};
        end
        sr = cau_pkg::sat_sum(sum_re);
        si = cau_pkg::sat_sum(sum_im);
        s1_next.add_re  = sr.val;
        s1_next.add_im  = si.val;
        s1_next.add_sat = sr.sat | si.sat;
    end

    // Stage 2: sum products for multiply or divide, form the divisor
    always_comb
    begin
        e_rr = {s1_reg.p_rr[cau_pkg::PROD_W-1], s1_reg.p_rr};
        e_ii = {s1_reg.p_ii[cau_pkg::PROD_W-1], s1_reg.p_ii};
        e_ir = {s1_reg.p_ir[cau_pkg::PROD_W-1], s1_reg.p_ir};
        e_ri = {s1_reg.p_ri[cau_pkg::PROD_W-1], s1_reg.p_ri};
        e_qr = {s1_reg.sq_r[cau_pkg::PROD_W-1], s1_reg.sq_r};
        e_qi = {s1_reg.sq_i[cau_pkg::PROD_W-1], s1_reg.sq_i};
        den_full = e_qr + e_qi;
        s2_next.op = s1_reg.op;
        if (s1_reg.op == cau_pkg::OP_MUL)
        begin
            s2_next.s_re = e_rr - e_ii;
            s2_next.s_im = e_ir + e_ri;
        end
        else
        begin
            s2_next.s_re = e_rr + e_ii;
            s2_next.s_im = e_ir - e_ri;
        end
        s2_next.den     = den_full[cau_pkg::PROD_W-1:0];
        s2_next.add_re  = s1_reg.add_re;
        s2_next.add_im  = s1_reg.add_im;
        s2_next.add_sat = s1_reg.add_sat;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= vld_in;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign vld_out = s2_vld_reg;
    assign d_out   = s2_reg;

endmodule
`default_nettype wire

// ===== src/cau_div_stage.sv =====
// One restoring-division stage: one quotient bit for both result lanes.
`default_nettype none
module cau_div_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              vld_in,
    input  wire cau_pkg::cau_div_t d_in,
    output logic                   vld_out,
    output cau_pkg::cau_div_t      d_out
);

    cau_pkg::cau_div_t d_next, d_reg;
    logic              vld_reg;

    function automatic cau_pkg::cau_lane_t step(input cau_pkg::cau_lane_t l,
                                                input logic [cau_pkg::PROD_W-1:0] den);
        cau_pkg::cau_lane_t       r;
        logic [cau_pkg::PROD_W:0] t;
        logic [cau_pkg::PROD_W:0] diff;
        r    = l;
        t    = {l.rem, l.num[cau_pkg::QUO_W-1]};
        diff = t - {1'b0, den};
        r.num = l.num << 1;
        if (t >= {1'b0, den})
        begin
            r.rem = diff[cau_pkg::PROD_W-1:0];
            r.quo = {l.quo[cau_pkg::QUO_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[cau_pkg::PROD_W-1:0];
            r.quo = {l.quo[cau_pkg::QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // Develop one quotient bit per lane
    always_comb
    begin
        d_next    = d_in;
        d_next.re = step(d_in.re, d_in.den);
        d_next.im = step(d_in.im, d_in.den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign vld_out = vld_reg;
    assign d_out   = d_reg;

endmodule
`default_nettype wire

// ===== src/complex_arithmetic_unit_core.sv =====
// Top level of the complex arithmetic unit: front end, divider chain and result stage.
//
// Pipelined signed fixed-point complex ALU (Q8.8 by default): add, subtract, multiply
// and divide with saturation and a zero-divisor flag. A new transaction is accepted
// every cycle while the output is not stalled; each passes from input to output through
// two front stages for the products and sums, one preparation stage, one
// restoring-division stage per quotient bit (DATA_WIDTH + 1 of them), and the output
// register. The whole pipeline holds while a result waits at the output.
`default_nettype none
module complex_arithmetic_unit_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [1:0]                            req_type,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] a_re,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] a_im,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] b_re,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] b_im,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [cau_pkg::DATA_WIDTH-1:0]      res_re,
    output logic signed [cau_pkg::DATA_WIDTH-1:0]      res_im,
    output logic                                       sat_flag,
    output logic                                       div_zero
);

    typedef struct packed {
        logic                      neg;
        logic [cau_pkg::PROD_W-1:0] mag;
    } sm_t;

    logic              pipe_en;
    logic              s2_vld;
    cau_pkg::cau_s2_t  s2_d;

    cau_pkg::cau_div_t s3_next;
    cau_pkg::cau_div_t div_d   [0:cau_pkg::DIV_STAGES];
    logic              div_vld [0:cau_pkg::DIV_STAGES];
    logic              s3_vld_reg;
    cau_pkg::cau_div_t s3_reg;

    logic                          out_vld_reg;
    logic [cau_pkg::DATA_WIDTH-1:0] re_reg, re_next, im_reg, im_next;
    logic                          sat_reg, sat_next, dz_reg, dz_next;

    sm_t                        sm_re, sm_im;
    cau_pkg::sat_t              mr, mi, dr, di;
    logic [cau_pkg::PROD_W-1:0] qm_re, qm_im;

    function automatic sm_t to_sm(input logic signed [cau_pkg::SUM_W-1:0] s);
        sm_t                       r;
        logic [cau_pkg::SUM_W-1:0] n;
        n     = -s;
        r.neg = s[cau_pkg::SUM_W-1];
        r.mag = r.neg ? n[cau_pkg::PROD_W-1:0] : s[cau_pkg::PROD_W-1:0];
        return r;
    endfunction

    function automatic cau_pkg::cau_lane_t prep(input sm_t v,
                                                input logic [cau_pkg::PROD_W-1:0] den);
        cau_pkg::cau_lane_t        r;
        logic [cau_pkg::NUM_W-1:0] n;
        logic [cau_pkg::NUM_W-1:0] hi;
        n     = cau_pkg::NUM_W'(v.mag) << cau_pkg::FRAC_BITS;
        hi    = n >> cau_pkg::QUO_W;
        r.neg = v.neg;
        r.ovf = hi >= cau_pkg::NUM_W'(den);
        r.rem = hi[cau_pkg::PROD_W-1:0];
        r.num = n[cau_pkg::QUO_W-1:0];
        r.quo = '0;
        return r;
    endfunction

    // Hold the whole pipeline while a result waits
    assign pipe_en  = !out_vld_reg || out_ready;
    assign in_ready = pipe_en;

    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .vld_in   (in_valid),
        .req_type (req_type),
        .a_re     (a_re),
        .a_im     (a_im),
        .b_re     (b_re),
        .b_im     (b_im),
        .vld_out  (s2_vld),
        .d_out    (s2_d)
    );

    // Stage 3: finish multiply, pass add/subtract results, set up the divider
    always_comb
    begin
        sm_re = to_sm(s2_d.s_re);
        sm_im = to_sm(s2_d.s_im);
        mr = cau_pkg::sat_mag(sm_re.neg, sm_re.mag >> cau_pkg::FRAC_BITS);
        mi = cau_pkg::sat_mag(sm_im.neg, sm_im.mag >> cau_pkg::FRAC_BITS);
        s3_next.op  = s2_d.op;
        s3_next.dz  = (s2_d.op == cau_pkg::OP_DIV) && (s2_d.den == '0);
        s3_next.den = s2_d.den;
        s3_next.re  = prep(sm_re, s2_d.den);
        s3_next.im  = prep(sm_im, s2_d.den);
        if (s2_d.op == cau_pkg::OP_MUL)
        begin
            s3_next.fast_re  = mr.val;
            s3_next.fast_im  = mi.val;
            s3_next.fast_sat = mr.sat | mi.sat;
        end
        else
        begin
            s3_next.fast_re  = s2_d.add_re;
            s3_next.fast_im  = s2_d.add_im;
            s3_next.fast_sat = s2_d.add_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (pipe_en)
            s3_vld_reg <= s2_vld;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            s3_reg <= s3_next;
    end

    assign div_d[0]   = s3_reg;
    assign div_vld[0] = s3_vld_reg;

    // Divider chain, one quotient bit per stage
    for (genvar g = 0; g < cau_pkg::DIV_STAGES; g++)
    begin : g_div
        cau_div_stage u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (pipe_en),
            .vld_in  (div_vld[g]),
            .d_in    (div_d[g]),
            .vld_out (div_vld[g+1]),
            .d_out   (div_d[g+1])
        );
    end

    // Output stage: pick the result and saturate the quotient
    always_comb
    begin
        qm_re = div_d[cau_pkg::DIV_STAGES].re.ovf ? '1
              : cau_pkg::PROD_W'(div_d[cau_pkg::DIV_STAGES].re.quo);
        qm_im = div_d[cau_pkg::DIV_STAGES].im.ovf ? '1
              : cau_pkg::PROD_W'(div_d[cau_pkg::DIV_STAGES].im.quo);
        dr = cau_pkg::sat_mag(div_d[cau_pkg::DIV_STAGES].re.neg, qm_re);
        di = cau_pkg::sat_mag(div_d[cau_pkg::DIV_STAGES].im.neg, qm_im);
        dz_next = 1'b0;
        if (div_d[cau_pkg::DIV_STAGES].op != cau_pkg::OP_DIV)
        begin
            re_next  = div_d[cau_pkg::DIV_STAGES].fast_re;
            im_next  = div_d[cau_pkg::DIV_STAGES].fast_im;
            sat_next = div_d[cau_pkg::DIV_STAGES].fast_sat;
        end
        else if (div_d[cau_pkg::DIV_STAGES].dz)
        begin
            re_next  = '0;
            im_next  = '0;
            sat_next = 1'b0;
            dz_next  = 1'b1;
        end
        else
        begin
            re_next  = dr.val;
            im_next  = di.val;
            sat_next = dr.sat | di.sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (pipe_en)
            out_vld_reg <= div_vld[cau_pkg::DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            sat_reg <= sat_next;
            dz_reg  <= dz_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign res_re    = re_reg;
    assign res_im    = im_reg;
    assign sat_flag  = sat_reg;
    assign div_zero  = dz_reg;

    // A zero-divisor result is clean zero with no saturation
    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_zero |-> res_re == '0 && res_im == '0 && !sat_flag)
        else $error("zero-divisor result not clean");

    // Saturation leaves at least one part at a limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sat_flag |-> (res_re == cau_pkg::MAX_VAL || res_re == cau_pkg::MIN_VAL
                                   || res_im == cau_pkg::MAX_VAL
                                   || res_im == cau_pkg::MIN_VAL))
        else $error("saturation flag without a saturated part");

    // A held pipeline keeps the valid bit of its last divider stage
    a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> div_vld[cau_pkg::DIV_STAGES] == $past(div_vld[cau_pkg::DIV_STAGES]))
        else $error("divider chain moved while held");

    // Nothing enters while a result is stalled
    a_no_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted during output stall");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the complex arithmetic unit core.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] re;
        logic [15:0] im;
        logic        sat;
        logic        dz;
    } cplx_res_t;

    typedef struct {
        cau_pkg::op_t op;
        logic [15:0]  ar;
        logic [15:0]  ai;
        logic [15:0]  br;
        logic [15:0]  bi;
        logic         typed;
        cplx_res_t    res;
    } stim_row_t;

    logic clk, rst_n;
    logic in_valid, out_ready;
    logic in_ready, out_valid;
    logic [1:0] req_type;
    logic signed [15:0] a_re, a_im, b_re, b_im;
    logic signed [15:0] res_re, res_im;
    logic sat_flag, div_zero;

    cplx_res_t expected_q[$];
    int errors;
    int sent;
    bit no_idle;

    complex_arithmetic_unit_core DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
        .out_valid(out_valid), .out_ready(out_ready), .res_re(res_re),
        .res_im(res_im), .sat_flag(sat_flag), .div_zero(div_zero)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Saturate a sign and magnitude to a 16-bit word
    function automatic logic [15:0] clamp_mag(input bit neg, input longint unsigned mag,
                                              inout logic sat);
        if (!neg) begin
            if (mag > 64'd32767) begin sat = 1'b1; return 16'h7fff; end
            return mag[15:0];
        end
        if (mag > 64'd32768) begin sat = 1'b1; return 16'h8000; end
        return 16'(-longint'(mag));
    endfunction

    function automatic logic [15:0] clamp_sum(input longint v, inout logic sat);
        if (v > 32767) begin sat = 1'b1; return 16'h7fff; end
        if (v < -32768) begin sat = 1'b1; return 16'h8000; end
        return v[15:0];
    endfunction

    // Fixed-point quotient of a product sum by |b|^2, truncated toward zero
    function automatic logic [15:0] quot_part(input longint s, input longint unsigned den,
                                              inout logic sat);
        longint unsigned mag, quo;
        mag = (s < 0) ? longint'(-s) : s;
        quo = mag / den;
        if (quo > 64'd65536) quo = 64'd65536;
        quo = ((quo << 8) | (((mag % den) << 8) / den));
        if (quo > 64'd65536) quo = 64'd65536;
        return clamp_mag(s < 0, quo, sat);
    endfunction

    function automatic cplx_res_t predict_cplx(input cau_pkg::op_t op,
                                               input logic signed [15:0] ar,
                                               input logic signed [15:0] ai,
                                               input logic signed [15:0] br,
                                               input logic signed [15:0] bi);
        cplx_res_t r;
        longint sr, si;
        longint unsigned den;
        r = '0;
        case (op)
            cau_pkg::OP_ADD: begin
                r.re = clamp_sum(longint'(ar) + br, r.sat);
                r.im = clamp_sum(longint'(ai) + bi, r.sat);
            end
            cau_pkg::OP_SUB: begin
                r.re = clamp_sum(longint'(ar) - br, r.sat);
                r.im = clamp_sum(longint'(ai) - bi, r.sat);
            end
            cau_pkg::OP_MUL: begin
                sr = longint'(ar) * br - longint'(ai) * bi;
                si = longint'(ai) * br + longint'(ar) * bi;
                r.re = clamp_mag(sr < 0, ((sr < 0) ? -sr : sr) >> 8, r.sat);
                r.im = clamp_mag(si < 0, ((si < 0) ? -si : si) >> 8, r.sat);
            end
            default: begin
                den = longint'(br) * br + longint'(bi) * bi;
                if (den == 0) r.dz = 1'b1;
                else begin
                    sr = longint'(ar) * br + longint'(ai) * bi;
                    si = longint'(ai) * br - longint'(ar) * bi;
                    r.re = quot_part(sr, den, r.sat);
                    r.im = quot_part(si, den, r.sat);
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // Drive one transaction and hold it until accepted
    task automatic send_cplx(input cau_pkg::op_t op, input logic [15:0] ar,
                             input logic [15:0] ai, input logic [15:0] br,
                             input logic [15:0] bi, input logic typed,
                             input cplx_res_t res);
        while (!no_idle && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= op;
        a_re <= ar; a_im <= ai; b_re <= br; b_im <= bi;
        expected_q.push_back(typed ? res : predict_cplx(op, ar, ai, br, bi));
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    // Randomly stall the result side
    always @(posedge clk) begin
        if (rst_n) out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 35);
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk) begin
        cplx_res_t e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", res_re, 16'h0000);
            end else begin
                e = expected_q.pop_front();
                if (res_re !== e.re) report_mismatch("res_re", res_re, e.re);
                if (res_im !== e.im) report_mismatch("res_im", res_im, e.im);
                if (sat_flag !== e.sat)
                    report_mismatch("sat_flag", 16'(sat_flag), 16'(e.sat));
                if (div_zero !== e.dz)
                    report_mismatch("div_zero", 16'(div_zero), 16'(e.dz));
            end
        end
    end

    function automatic logic [15:0] rand_val();
        case ($urandom_range(5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(1024)) - 512);
            3: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    stim_row_t dir_tab[$];

    function automatic stim_row_t row(input cau_pkg::op_t op, input logic [15:0] ar,
                                      input logic [15:0] ai, input logic [15:0] br,
                                      input logic [15:0] bi, input logic typed,
                                      input cplx_res_t res);
        stim_row_t s;
        s.op = op; s.ar = ar; s.ai = ai; s.br = br; s.bi = bi;
        s.typed = typed; s.res = res;
        return s;
    endfunction

    initial begin
        cau_pkg::op_t op;
        errors = 0; sent = 0; no_idle = 0;
        rst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b0;
        req_type = cau_pkg::OP_ADD; a_re = '0; a_im = '0; b_re = '0; b_im = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows: typed where obvious, predicted otherwise
        dir_tab.push_back(row(cau_pkg::OP_ADD, 16'h0100, 16'h0200, 16'h0100, 16'h0100, 1,
                              '{16'h0200, 16'h0300, 1'b0, 1'b0}));
        dir_tab.push_back(row(cau_pkg::OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1,
                              '{16'h7fff, 16'h8000, 1'b1, 1'b0}));
        dir_tab.push_back(row(cau_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff, 1,
                              '{16'h8000, 16'h7fff, 1'b1, 1'b0}));
        dir_tab.push_back(row(cau_pkg::OP_SUB, 16'h0300, 16'h0000, 16'h0100, 16'h0100, 1,
                              '{16'h0200, 16'hff00, 1'b0, 1'b0}));
        dir_tab.push_back(row(cau_pkg::OP_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 1,
                              '{16'h0100, 16'h0000, 1'b0, 1'b0}));
        dir_tab.push_back(row(cau_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                              0, '0));
        dir_tab.push_back(row(cau_pkg::OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000,
                              0, '0));
        dir_tab.push_back(row(cau_pkg::OP_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001,
                              0, '0));
        dir_tab.push_back(row(cau_pkg::OP_DIV, 16'h1234, 16'h5678, 16'h0000, 16'h0000, 1,
                              '{16'h0000, 16'h0000, 1'b0, 1'b1}));
        dir_tab.push_back(row(cau_pkg::OP_DIV, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 1,
                              '{16'h0100, 16'h0000, 1'b0, 1'b0}));
        dir_tab.push_back(row(cau_pkg::OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000,
                              0, '0));
        dir_tab.push_back(row(cau_pkg::OP_DIV, 16'h8000, 16'h8000, 16'h0000, 16'h0001,
                              0, '0));
        dir_tab.push_back(row(cau_pkg::OP_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                              0, '0));
        dir_tab.push_back(row(cau_pkg::OP_DIV, 16'hffff, 16'h0001, 16'h7fff, 16'h7fff,
                              0, '0));
        dir_tab.push_back(row(cau_pkg::OP_DIV, 16'h0100, 16'h0100, 16'hffff, 16'h0000,
                              0, '0));
        foreach (dir_tab[i])
            send_cplx(dir_tab[i].op, dir_tab[i].ar, dir_tab[i].ai, dir_tab[i].br,
                      dir_tab[i].bi, dir_tab[i].typed, dir_tab[i].res);

        // Random transactions, with a no-idle stretch and one full drain
        for (int n = 0; n < 1150; n++) begin
            no_idle = (n >= 300 && n < 500);
            if (n == 700) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (expected_q.size() != 0) @(posedge clk);
            end
            op = cau_pkg::op_t'($urandom_range(3));
            send_cplx(op, rand_val(), rand_val(), rand_val(), rand_val(), 0, '0);
        end
        in_valid <= 1'b0;
        no_idle = 0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
